/* rtl/core/pdsamp_pkg.sv */
package pdsamp_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_RESEED    = 3'd0;
   localparam logic [2:0] KIND_RAW       = 3'd1;
   localparam logic [2:0] KIND_BOUNDED   = 3'd2;
   localparam logic [2:0] KIND_BERNOULLI = 3'd3;
   localparam logic [2:0] KIND_BINOMIAL  = 3'd4;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_SEED = 2'd1;
   localparam logic [1:0] STATUS_UNSEEDED  = 2'd2;

   // First and last phase of the three-phase 64-bit multiply.
   localparam logic [1:0] MUL_PHASE_FIRST = 2'd0;
   localparam logic [1:0] MUL_PHASE_LAST  = 2'd2;

   // Multiplier constants.
   localparam logic [63:0] MIX_A     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_B     = 64'h94d049bb133111eb;
   localparam logic [63:0] LCG_MULT  = 64'h5851f42d4c957f2d;
   localparam logic [63:0] PERM_MULT = 64'haef17502108ef2d9;

   // Bernoulli resolution limit and word size.
   localparam logic [6:0] WORD_BITS = 7'd64;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] seed;
      logic [63:0] low_bound;
      logic [63:0] high_bound;
      logic [63:0] prob_numerator;
      logic [6:0]  prob_bits;
      logic [15:0] trial_count;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      CSEL_MIX_A,
      CSEL_MIX_B,
      CSEL_LCG,
      CSEL_PERM
   } csel_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR_SEED,
      OP_ERR_UNSEEDED,
      OP_BOUND_LOW,
      OP_MIX_PRE,
      OP_MUL,
      OP_MIX_MID,
      OP_MIX_POST,
      OP_SET_STATE,
      OP_SET_INC,
      OP_XS_STEP,
      OP_PCG_PRE,
      OP_PCG_ADV,
      OP_PCG_OUT,
      OP_RAW_TAKE,
      OP_BOUND_TAKE,
      OP_BERN_INIT,
      OP_BERN_ACC,
      OP_BERN_SKIP,
      OP_BERN_TAKE,
      OP_BINO_ADD,
      OP_BINO_TAKE,
      OP_RESPOND
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_MIX_PRE,
      S_MIX_MID,
      S_MIX_POST,
      S_MIX_STORE,
      S_MUL,
      S_STEP,
      S_PCG_ADV,
      S_PCG_OUT,
      S_USE,
      S_BERN,
      S_BERN_END,
      S_BINO_CHK,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      op_type     op;
      csel_type   csel;
      logic [1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       seeded;
      logic       seed_zero;
      logic       span_zero;
      logic       k_zero;
      logic       pc_done;
      logic       bit_active;
      logic       bound_ok;
      logic       gsel;
      logic       out_free;
   } stat_type;

endpackage

/* rtl/core/prng_distribution_sampler_unit.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_type: kind, seed, bounds, n, m, k
// rsp_      out        rsp_valid/rsp_stall  rsp_type: value, status
// csr_      in         csr_write_enable     csr_write_data: generator select
//
// One request at a time: an accept, a dispatch and a result state around the work.
// A core step is an xorshift64 update, or for PCG64 an LCG advance and an output
// permutation on the shared 32x32 multiplier. A reseed mixes the seed into state and
// increment; a raw draw or a bounded attempt is a step and a use; a Bernoulli word is
// a step per active bit, a skip per other bit and an end; a binomial adds a check per 64 trials.
// Reset is synchronous and clears the generator to unseeded. A stalled result beat
// holds in the output register; the next request is taken then.
module prng_distribution_sampler_unit
   import pdsamp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   pdsamp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Generator state, multiplier and result register.
   pdsamp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

/* rtl/core/pdsamp_dpath.sv */
module pdsamp_dpath
   import pdsamp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output stat_type stat,
   input  req_type req_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // Fill every bit below the leading one.
   function automatic logic [63:0] smear64(input logic [63:0] v);
      logic [63:0] s;
      s = v;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      s = s | (s >> 32);
      return s;
   endfunction

   // Persistent generator state and configuration.
   logic [63:0] gen_state_ff, gen_state_in;
   logic [63:0] inc_ff, inc_in;
   logic        seeded_ff, seeded_in;
   logic        gsel_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   // Per-request working registers.
   logic [2:0]  kind_ff, kind_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] span_ff, span_in;
   logic [63:0] mask_ff;
   logic [63:0] n_ff, n_in;
   logic [6:0]  m_ff, m_in;
   logic [15:0] k_ff, k_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] draw_ff, draw_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [6:0]  pc_ff, pc_in;
   logic [63:0] value_ff, value_in;
   logic [1:0]  status_ff, status_in;

   logic [63:0] mul_const;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] xs1, xs2, xs3;
   logic [5:0]  perm_shift;
   logic [63:0] n_low;
   logic [6:0]  tail_shift;

   // Constant operand of the shared multiplier.
   always_comb begin
      case (cmd.csel)
         CSEL_MIX_A: mul_const = MIX_A;
         CSEL_MIX_B: mul_const = MIX_B;
         CSEL_LCG:   mul_const = LCG_MULT;
         CSEL_PERM:  mul_const = PERM_MULT;
         default:    mul_const = MIX_A;
      endcase
   end

   // One 32x32 partial product per phase; the low 64 bits of x * constant.
   assign mul_a = (cmd.phase == MUL_PHASE_LAST) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (cmd.phase == MUL_PHASE_FIRST || cmd.phase == MUL_PHASE_LAST) ?
                  mul_const[31:0] : mul_const[63:32];
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // Xorshift step and the PCG output rotation amount.
   assign xs1        = gen_state_ff ^ (gen_state_ff << 13);
   assign xs2        = xs1 ^ (xs1 >> 7);
   assign xs3        = xs2 ^ (xs2 << 17);
   assign perm_shift = 6'(x_ff[63:59]) + 6'd5;

   // Bits of n up to and including the current position.
   assign n_low      = n_ff & ~((64'hffff_ffff_ffff_ffff << pc_ff[5:0]) << 1);
   assign tail_shift = WORD_BITS - 7'(k_ff);

   // Next-value logic for every datapath operation.
   always_comb begin
      gen_state_in   = gen_state_ff;
      inc_in         = inc_ff;
      seeded_in      = seeded_ff;
      kind_in        = kind_ff;
      seed_in        = seed_ff;
      lo_in          = lo_ff;
      span_in        = span_ff;
      n_in           = n_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      x_in           = x_ff;
      prod_in        = prod_ff;
      draw_in        = draw_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      pc_in          = pc_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      case (cmd.op)
         OP_LOAD: begin
            kind_in   = req_payload.kind;
            seed_in   = req_payload.seed;
            x_in      = req_payload.seed;
            lo_in     = req_payload.low_bound;
            span_in   = req_payload.high_bound - req_payload.low_bound;
            n_in      = req_payload.prob_numerator;
            m_in      = (req_payload.prob_bits > WORD_BITS) ? WORD_BITS
                                                            : req_payload.prob_bits;
            k_in      = req_payload.trial_count;
            cnt_in    = '0;
            value_in  = '0;
            status_in = STATUS_OK;
         end
         OP_ERR_SEED:     status_in = STATUS_ZERO_SEED;
         OP_ERR_UNSEEDED: status_in = STATUS_UNSEEDED;
         OP_BOUND_LOW:    value_in  = lo_ff;
         OP_MIX_PRE:      x_in      = x_ff ^ (x_ff >> 30);
         OP_MUL: begin
            if (cmd.phase == MUL_PHASE_FIRST) begin
               prod_in = mul_p;
            end else begin
               prod_in = prod_ff + {mul_p[31:0], 32'd0};
            end
         end
         OP_MIX_MID:   x_in = prod_ff ^ (prod_ff >> 27);
         OP_MIX_POST:  x_in = prod_ff ^ (prod_ff >> 31);
         OP_SET_STATE: gen_state_in = x_ff;
         OP_SET_INC: begin
            inc_in    = x_ff | 64'd1;
            seeded_in = 1'b1;
         end
         OP_XS_STEP: begin
            gen_state_in = xs3;
            draw_in      = xs3;
         end
         OP_PCG_PRE: x_in = gen_state_ff;
         OP_PCG_ADV: begin
            gen_state_in = prod_ff + inc_ff;
            x_in         = (x_ff >> perm_shift) ^ x_ff;
         end
         OP_PCG_OUT:    draw_in  = prod_ff ^ (prod_ff >> 43);
         OP_RAW_TAKE:   value_in = draw_ff;
         OP_BOUND_TAKE: value_in = (draw_ff & mask_ff) + lo_ff;
         OP_BERN_INIT: begin
            acc_in = '0;
            pc_in  = '0;
         end
         OP_BERN_ACC: begin
            acc_in = n_ff[pc_ff[5:0]] ? (acc_ff | draw_ff) : (acc_ff & draw_ff);
            pc_in  = pc_ff + 7'd1;
         end
         OP_BERN_SKIP: pc_in    = pc_ff + 7'd1;
         OP_BERN_TAKE: value_in = acc_ff;
         OP_BINO_ADD: begin
            if (k_ff > 16'(WORD_BITS)) begin
               cnt_in = cnt_ff + 16'($countones(acc_ff));
               k_in   = k_ff - 16'(WORD_BITS);
            end else begin
               cnt_in = cnt_ff + 16'($countones(acc_ff >> tail_shift[5:0]));
               k_in   = '0;
            end
         end
         OP_BINO_TAKE: value_in     = {48'd0, cnt_ff};
         OP_RESPOND: begin
            rsp_valid_in          = 1'b1;
            rsp_payload_in.value  = value_ff;
            rsp_payload_in.status = status_ff;
         end
         default: begin
         end
      endcase
   end

   // Control and generator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
         inc_ff       <= 64'd1;
         seeded_ff    <= 1'b0;
         gsel_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_state_ff <= gen_state_in;
         inc_ff       <= inc_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            gsel_ff <= csr_write_data;
         end
      end
   end

   // Working registers carry no reset.
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      seed_ff        <= seed_in;
      lo_ff          <= lo_in;
      span_ff        <= span_in;
      mask_ff        <= smear64(span_ff);
      n_ff           <= n_in;
      m_ff           <= m_in;
      k_ff           <= k_in;
      x_ff           <= x_in;
      prod_ff        <= prod_in;
      draw_ff        <= draw_in;
      acc_ff         <= acc_in;
      cnt_ff         <= cnt_in;
      pc_ff          <= pc_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Status toward the controller.
   always_comb begin
      stat.kind       = kind_ff;
      stat.seeded     = seeded_ff;
      stat.seed_zero  = (seed_ff == 64'd0);
      stat.span_zero  = (span_ff == 64'd0);
      stat.k_zero     = (k_ff == 16'd0);
      stat.pc_done    = (pc_ff >= m_ff);
      stat.bit_active = (n_low != 64'd0);
      stat.bound_ok   = ((draw_ff & mask_ff) <= span_ff);
      stat.gsel       = gsel_ff;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/core/pdsamp_ctrl.sv */
module pdsamp_ctrl
   import pdsamp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   ctrl_state_type ret_ff, ret_in;
   csel_type       csel_ff, csel_in;
   logic [1:0]     phase_ff, phase_in;
   logic           pass_ff, pass_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      csel_in  = csel_ff;
      phase_in = phase_ff;
      pass_in  = pass_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_RESEED: begin
                  pass_in  = 1'b0;
                  state_in = stat.seed_zero ? S_RESP : S_MIX_PRE;
               end
               KIND_RAW:       state_in = stat.seeded ? S_STEP : S_RESP;
               KIND_BOUNDED: begin
                  state_in = (!stat.seeded || stat.span_zero) ? S_RESP : S_STEP;
               end
               KIND_BERNOULLI: state_in = stat.seeded ? S_BERN : S_RESP;
               KIND_BINOMIAL: begin
                  state_in = (!stat.seeded || stat.k_zero) ? S_RESP : S_BERN;
               end
               default:        state_in = S_RESP;
            endcase
         end
         S_MIX_PRE: begin
            csel_in  = CSEL_MIX_A;
            ret_in   = S_MIX_MID;
            phase_in = MUL_PHASE_FIRST;
            state_in = S_MUL;
         end
         S_MIX_MID: begin
            csel_in  = CSEL_MIX_B;
            ret_in   = S_MIX_POST;
            phase_in = MUL_PHASE_FIRST;
            state_in = S_MUL;
         end
         S_MIX_POST: state_in = S_MIX_STORE;
         S_MIX_STORE: begin
            pass_in  = 1'b1;
            state_in = pass_ff ? S_RESP : S_MIX_PRE;
         end
         S_MUL: begin
            if (phase_ff == MUL_PHASE_LAST) begin
               state_in = ret_ff;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         S_STEP: begin
            if (stat.gsel) begin
               state_in = S_USE;
            end else begin
               csel_in  = CSEL_LCG;
               ret_in   = S_PCG_ADV;
               phase_in = MUL_PHASE_FIRST;
               state_in = S_MUL;
            end
         end
         S_PCG_ADV: begin
            csel_in  = CSEL_PERM;
            ret_in   = S_PCG_OUT;
            phase_in = MUL_PHASE_FIRST;
            state_in = S_MUL;
         end
         S_PCG_OUT: state_in = S_USE;
         S_USE: begin
            case (stat.kind)
               KIND_RAW:     state_in = S_RESP;
               KIND_BOUNDED: state_in = stat.bound_ok ? S_RESP : S_STEP;
               default:      state_in = S_BERN;
            endcase
         end
         S_BERN: begin
            if (stat.pc_done) begin
               state_in = S_BERN_END;
            end else if (stat.bit_active) begin
               state_in = S_STEP;
            end
         end
         S_BERN_END: state_in = (stat.kind == KIND_BINOMIAL) ? S_BINO_CHK : S_RESP;
         S_BINO_CHK: state_in = stat.k_zero ? S_RESP : S_BERN;
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.csel  = csel_ff;
      cmd.phase = phase_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_RESEED: begin
                  if (stat.seed_zero) cmd.op = OP_ERR_SEED;
               end
               KIND_RAW: begin
                  if (!stat.seeded) cmd.op = OP_ERR_UNSEEDED;
               end
               KIND_BOUNDED: begin
                  if (!stat.seeded) cmd.op = OP_ERR_UNSEEDED;
                  else if (stat.span_zero) cmd.op = OP_BOUND_LOW;
               end
               KIND_BERNOULLI, KIND_BINOMIAL: begin
                  cmd.op = stat.seeded ? OP_BERN_INIT : OP_ERR_UNSEEDED;
               end
               default: cmd.op = OP_NONE;
            endcase
         end
         S_MIX_PRE:   cmd.op = OP_MIX_PRE;
         S_MIX_MID:   cmd.op = OP_MIX_MID;
         S_MIX_POST:  cmd.op = OP_MIX_POST;
         S_MIX_STORE: cmd.op = pass_ff ? OP_SET_INC : OP_SET_STATE;
         S_MUL:       cmd.op = OP_MUL;
         S_STEP:      cmd.op = stat.gsel ? OP_XS_STEP : OP_PCG_PRE;
         S_PCG_ADV:   cmd.op = OP_PCG_ADV;
         S_PCG_OUT:   cmd.op = OP_PCG_OUT;
         S_USE: begin
            case (stat.kind)
               KIND_RAW:     cmd.op = OP_RAW_TAKE;
               KIND_BOUNDED: cmd.op = stat.bound_ok ? OP_BOUND_TAKE : OP_NONE;
               default:      cmd.op = OP_BERN_ACC;
            endcase
         end
         S_BERN: begin
            if (!stat.pc_done && !stat.bit_active) cmd.op = OP_BERN_SKIP;
         end
         S_BERN_END: cmd.op = (stat.kind == KIND_BINOMIAL) ? OP_BINO_ADD : OP_BERN_TAKE;
         S_BINO_CHK: cmd.op = stat.k_zero ? OP_BINO_TAKE : OP_BERN_INIT;
         S_RESP: begin
            if (stat.out_free) cmd.op = OP_RESPOND;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         csel_ff  <= CSEL_MIX_A;
         phase_ff <= MUL_PHASE_FIRST;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         csel_ff  <= csel_in;
         phase_ff <= phase_in;
         pass_ff  <= pass_in;
      end
   end

endmodule
